### rtl/core/fdpf_pkg.sv
// ----------------------------------------------------------------------------
// fdpf_pkg: shared types and constants of the facing dot product filter.
// Holds the CORDIC arctangent table, register indexes and compare rules.
// ----------------------------------------------------------------------------
`default_nettype none
package fdpf_pkg;

  localparam int unsigned STEPS = 20;
  // Vector datapath width: normalized components stay below 2^32 in magnitude
  // and grow by up to sqrt(2) times the CORDIC gain, so 35 signed bits hold them.
  localparam int unsigned VW = 35;
  // Cosine datapath width, Q2.30 plus growth.
  localparam int unsigned CW = 33;
  localparam logic signed [CW-1:0] COS_START = 33'sd652032874;

  typedef enum logic [2:0] {
    REG_TARGET_X    = 3'd0,
    REG_TARGET_Y    = 3'd1,
    REG_THRESHOLD   = 3'd2,
    REG_RULE        = 3'd3,
    REG_FILTER_EN   = 3'd4,
    REG_SCORE_EN    = 3'd5
  } reg_index_t;

  typedef enum logic [2:0] {
    RULE_LT = 3'd0,
    RULE_LE = 3'd1,
    RULE_EQ = 3'd2,
    RULE_GE = 3'd3
  } rule_t;

  // Per-item bookkeeping carried beside the vectoring run.
  typedef struct packed {
    logic        valid;
    logic        nonzero;
    logic [15:0] heading;
  } vec_tag_t;

  // Per-item bookkeeping carried beside the rotation run.
  typedef struct packed {
    logic valid;
    logic nonzero;
    logic flip;
  } rot_tag_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] r;
    begin
      unique case (i)
        5'd0:  r = 32'd536870912;
        5'd1:  r = 32'd316933406;
        5'd2:  r = 32'd167458907;
        5'd3:  r = 32'd85004756;
        5'd4:  r = 32'd42667331;
        5'd5:  r = 32'd21354465;
        5'd6:  r = 32'd10679838;
        5'd7:  r = 32'd5340245;
        5'd8:  r = 32'd2670163;
        5'd9:  r = 32'd1335087;
        5'd10: r = 32'd667544;
        5'd11: r = 32'd333772;
        5'd12: r = 32'd166886;
        5'd13: r = 32'd83443;
        5'd14: r = 32'd41722;
        5'd15: r = 32'd20861;
        5'd16: r = 32'd10430;
        5'd17: r = 32'd5215;
        5'd18: r = 32'd2608;
        5'd19: r = 32'd1304;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

### rtl/core/fdpf_norm_cell.sv
// ----------------------------------------------------------------------------
// fdpf_norm_cell: one step of the normalizing shift chain.
// Shifts the vector left by SHIFT in one stage while both components stay inside 2^(32-SHIFT).
// Five cells shift by 16, 8, 4, 2 and 1, so any nonzero vector is normalized.
// ----------------------------------------------------------------------------
`default_nettype none
module fdpf_norm_cell #(
  parameter int unsigned SHIFT = 1
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         advance,
  input  wire signed [32:0]           in_x,
  input  wire signed [32:0]           in_y,
  input  wire fdpf_pkg::vec_tag_t     in_tag,
  output logic signed [32:0]          out_x,
  output logic signed [32:0]          out_y,
  output fdpf_pkg::vec_tag_t          out_tag
);

  localparam logic signed [32:0] LIM = 33'sd1 <<< (32 - SHIFT);

  logic fits;
  logic signed [32:0] sx;
  logic signed [32:0] sy;

  // The shift is taken when every doubling in it starts strictly inside
  // plus or minus 2^31, which is the case when both components lie strictly
  // inside plus or minus 2^(32-SHIFT).
  always_comb begin
    fits = (in_x < LIM) && (in_x > -LIM) && (in_y < LIM) && (in_y > -LIM);
    sx = in_x <<< SHIFT;
    sy = in_y <<< SHIFT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_tag.valid <= 1'b0;
    end else if (advance) begin
      out_tag.valid <= in_tag.valid;
    end
    if (advance) begin
      out_tag.nonzero <= in_tag.nonzero;
      out_tag.heading <= in_tag.heading;
      out_x <= fits ? sx : in_x;
      out_y <= fits ? sy : in_y;
    end
  end

endmodule
`default_nettype wire

### rtl/core/fdpf_vec_cell.sv
// ----------------------------------------------------------------------------
// fdpf_vec_cell: one vectoring CORDIC iteration.
// Rotates the vector toward the x axis and accumulates the angle.
// ----------------------------------------------------------------------------
`default_nettype none
module fdpf_vec_cell #(
  parameter int unsigned STEP = 0
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              advance,
  input  wire signed [fdpf_pkg::VW-1:0]    in_x,
  input  wire signed [fdpf_pkg::VW-1:0]    in_y,
  input  wire [31:0]                       in_z,
  input  wire fdpf_pkg::vec_tag_t          in_tag,
  output logic signed [fdpf_pkg::VW-1:0]   out_x,
  output logic signed [fdpf_pkg::VW-1:0]   out_y,
  output logic [31:0]                      out_z,
  output fdpf_pkg::vec_tag_t               out_tag
);

  localparam logic [31:0] ATAN = fdpf_pkg::atan_entry(5'(STEP));

  logic signed [fdpf_pkg::VW-1:0] xs;
  logic signed [fdpf_pkg::VW-1:0] ys;

  always_comb begin
    xs = in_x >>> STEP;
    ys = in_y >>> STEP;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_tag.valid <= 1'b0;
    end else if (advance) begin
      out_tag.valid <= in_tag.valid;
    end
    if (advance) begin
      out_tag.nonzero <= in_tag.nonzero;
      out_tag.heading <= in_tag.heading;
      if (in_y > 0) begin
        out_x <= in_x + ys;
        out_y <= in_y - xs;
        out_z <= in_z + ATAN;
      end else begin
        out_x <= in_x - ys;
        out_y <= in_y + xs;
        out_z <= in_z - ATAN;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/fdpf_rot_cell.sv
// ----------------------------------------------------------------------------
// fdpf_rot_cell: one rotation CORDIC iteration.
// Rotates the cosine vector by the next table angle toward the residual.
// ----------------------------------------------------------------------------
`default_nettype none
module fdpf_rot_cell #(
  parameter int unsigned STEP = 0
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              advance,
  input  wire signed [fdpf_pkg::CW-1:0]    in_x,
  input  wire signed [fdpf_pkg::CW-1:0]    in_y,
  input  wire signed [32:0]                in_z,
  input  wire fdpf_pkg::rot_tag_t          in_tag,
  output logic signed [fdpf_pkg::CW-1:0]   out_x,
  output logic signed [fdpf_pkg::CW-1:0]   out_y,
  output logic signed [32:0]               out_z,
  output fdpf_pkg::rot_tag_t               out_tag
);

  localparam logic signed [32:0] ATAN = $signed({1'b0, fdpf_pkg::atan_entry(5'(STEP))});

  logic signed [fdpf_pkg::CW-1:0] xs;
  logic signed [fdpf_pkg::CW-1:0] ys;

  always_comb begin
    xs = in_x >>> STEP;
    ys = in_y >>> STEP;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_tag.valid <= 1'b0;
    end else if (advance) begin
      out_tag.valid <= in_tag.valid;
    end
    if (advance) begin
      out_tag.nonzero <= in_tag.nonzero;
      out_tag.flip    <= in_tag.flip;
      if (in_z >= 0) begin
        out_x <= in_x - ys;
        out_y <= in_y + xs;
        out_z <= in_z - ATAN;
      end else begin
        out_x <= in_x + ys;
        out_y <= in_y - xs;
        out_z <= in_z + ATAN;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/facing_dot_product_filter_unit.sv
// ----------------------------------------------------------------------------
// facing_dot_product_filter_unit: facing test of objects against a target.
// Computes the cosine between an object's heading and its direction to the
// target point, then a filter flag and a score from it.
// ----------------------------------------------------------------------------
// Usage: each input transaction carries position_x, position_y (Q16.16) and
// heading (binary angle). Each one yields exactly one output transaction with
// filtered, score and dot_value, in input order.
// The datapath is a chain of cells: a subtract stage, five normalizing shift
// cells, twenty vectoring CORDIC cells, a heading subtract stage, twenty
// rotation CORDIC cells, a rounding stage and the output register. That is
// 49 register stages. Throughput is one transaction per cycle while the
// receiver does not stall; every cell advances together.
// When the receiver stalls with the output register full, the whole chain
// holds still and stall is raised toward the sender; the output register
// can be refilled in the cycle it is taken, so no bubble appears.
// Reset (rst, synchronous) empties the chain and loads the register reset
// values. Configuration writes are expected only while the chain is empty;
// indexes beyond the register list are ignored.
// ----------------------------------------------------------------------------
`default_nettype none
module facing_dot_product_filter_unit (
  input  wire                clk,
  input  wire                rst,
  input  wire                cfg_we,
  input  wire [2:0]          cfg_index,
  input  wire [31:0]         cfg_data,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire signed [31:0]  position_x,
  input  wire signed [31:0]  position_y,
  input  wire [15:0]         heading,
  output logic               out_valid,
  input  wire                out_stall,
  output logic               filtered,
  output logic [16:0]        score,
  output logic signed [16:0] dot_value
);

  localparam int unsigned NS = fdpf_pkg::STEPS;
  localparam int unsigned VW = fdpf_pkg::VW;
  localparam int unsigned CW = fdpf_pkg::CW;

  // Configuration registers.
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  logic signed [16:0] threshold;
  logic [2:0]         compare_rule;
  logic               filter_enable;
  logic               score_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_x      <= 32'sd65536;
      target_y      <= 32'sd0;
      threshold     <= 17'sd0;
      compare_rule  <= 3'd1;
      filter_enable <= 1'b0;
      score_enable  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fdpf_pkg::REG_TARGET_X:  target_x      <= cfg_data;
        fdpf_pkg::REG_TARGET_Y:  target_y      <= cfg_data;
        fdpf_pkg::REG_THRESHOLD: threshold     <= cfg_data[16:0];
        fdpf_pkg::REG_RULE:      compare_rule  <= cfg_data[2:0];
        fdpf_pkg::REG_FILTER_EN: filter_enable <= cfg_data[0];
        fdpf_pkg::REG_SCORE_EN:  score_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The chain advances unless the output register holds a result that the
  // receiver is stalling.
  logic advance;
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  // Stage 0: difference vector.
  logic signed [32:0] d_x;
  logic signed [32:0] d_y;
  fdpf_pkg::vec_tag_t d_tag;
  logic signed [32:0] dx_c;
  logic signed [32:0] dy_c;

  always_comb begin
    dx_c = 33'(target_x) - 33'(position_x);
    dy_c = 33'(target_y) - 33'(position_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_tag.valid <= 1'b0;
    end else if (advance) begin
      d_tag.valid <= in_valid;
    end
    if (advance) begin
      d_x             <= dx_c;
      d_y             <= dy_c;
      d_tag.nonzero   <= (dx_c != 33'sd0) || (dy_c != 33'sd0);
      d_tag.heading   <= heading;
    end
  end

  // Normalizing shift cells: 16, 8, 4, 2, 1.
  logic signed [32:0] n_x [0:5];
  logic signed [32:0] n_y [0:5];
  fdpf_pkg::vec_tag_t n_tag [0:5];
  assign n_x[0]   = d_x;
  assign n_y[0]   = d_y;
  assign n_tag[0] = d_tag;

  for (genvar g = 0; g < 5; g++) begin : g_norm
    fdpf_norm_cell #(.SHIFT(16 >> g)) u_cell (
      .clk(clk), .rst(rst), .advance(advance),
      .in_x(n_x[g]), .in_y(n_y[g]), .in_tag(n_tag[g]),
      .out_x(n_x[g+1]), .out_y(n_y[g+1]), .out_tag(n_tag[g+1])
    );
  end

  // Fold into the right half plane; this feeds the first vectoring cell.
  logic signed [VW-1:0] v_x [0:NS];
  logic signed [VW-1:0] v_y [0:NS];
  logic [31:0]          v_z [0:NS];
  fdpf_pkg::vec_tag_t   v_tag [0:NS];

  always_comb begin
    if (n_x[5] < 0) begin
      v_x[0] = -VW'(n_x[5]);
      v_y[0] = -VW'(n_y[5]);
      v_z[0] = 32'h8000_0000;
    end else begin
      v_x[0] = VW'(n_x[5]);
      v_y[0] = VW'(n_y[5]);
      v_z[0] = 32'd0;
    end
    v_tag[0] = n_tag[5];
  end

  for (genvar g = 0; g < NS; g++) begin : g_vec
    fdpf_vec_cell #(.STEP(g)) u_cell (
      .clk(clk), .rst(rst), .advance(advance),
      .in_x(v_x[g]), .in_y(v_y[g]), .in_z(v_z[g]), .in_tag(v_tag[g]),
      .out_x(v_x[g+1]), .out_y(v_y[g+1]), .out_z(v_z[g+1]),
      .out_tag(v_tag[g+1])
    );
  end

  // Heading subtract and quadrant fold, registered.
  logic signed [32:0] a_z;
  fdpf_pkg::rot_tag_t a_tag;
  logic [31:0] ang_c;
  logic        flip_c;
  logic [31:0] folded_c;

  always_comb begin
    ang_c    = v_z[NS] - {v_tag[NS].heading, 16'd0};
    flip_c   = ang_c[31] ^ ang_c[30];
    folded_c = flip_c ? (ang_c + 32'h8000_0000) : ang_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_tag.valid <= 1'b0;
    end else if (advance) begin
      a_tag.valid <= v_tag[NS].valid;
    end
    if (advance) begin
      a_tag.nonzero <= v_tag[NS].nonzero;
      a_tag.flip    <= flip_c;
      a_z           <= $signed({folded_c[31], folded_c});
    end
  end

  logic signed [CW-1:0] r_x [0:NS];
  logic signed [CW-1:0] r_y [0:NS];
  logic signed [32:0]   r_z [0:NS];
  fdpf_pkg::rot_tag_t   r_tag [0:NS];
  assign r_x[0]   = fdpf_pkg::COS_START;
  assign r_y[0]   = '0;
  assign r_z[0]   = a_z;
  assign r_tag[0] = a_tag;

  for (genvar g = 0; g < NS; g++) begin : g_rot
    fdpf_rot_cell #(.STEP(g)) u_cell (
      .clk(clk), .rst(rst), .advance(advance),
      .in_x(r_x[g]), .in_y(r_y[g]), .in_z(r_z[g]), .in_tag(r_tag[g]),
      .out_x(r_x[g+1]), .out_y(r_y[g+1]), .out_z(r_z[g+1]),
      .out_tag(r_tag[g+1])
    );
  end

  // Round half up to Q1.15, negate for the folded half, saturate; zero on the target.
  logic signed [CW:0]  rnd_c;
  logic signed [18:0]  q_c;
  logic signed [18:0]  s_c;
  logic signed [16:0]  dot_c;

  always_comb begin
    rnd_c = (CW+1)'(r_x[NS]) + (CW+1)'(16384);
    q_c   = 19'(rnd_c >>> 15);
    s_c   = r_tag[NS].flip ? -q_c : q_c;
    if (!r_tag[NS].nonzero) begin
      dot_c = 17'sd0;
    end else if (s_c > 19'sd32768) begin
      dot_c = 17'sd32768;
    end else if (s_c < -19'sd32768) begin
      dot_c = -17'sd32768;
    end else begin
      dot_c = 17'(s_c);
    end
  end

  logic signed [16:0] dot_q;
  logic               dot_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_valid <= 1'b0;
    end else if (advance) begin
      dot_valid <= r_tag[NS].valid;
    end
    if (advance) begin
      dot_q <= dot_c;
    end
  end

  // Compare and score, into the output register.
  logic flag_c;

  always_comb begin
    priority case (compare_rule)
      fdpf_pkg::RULE_LT: flag_c = dot_q <  threshold;
      fdpf_pkg::RULE_LE: flag_c = dot_q <= threshold;
      fdpf_pkg::RULE_EQ: flag_c = dot_q == threshold;
      fdpf_pkg::RULE_GE: flag_c = dot_q >= threshold;
      default:           flag_c = dot_q >  threshold;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= dot_valid;
    end
    if (advance) begin
      filtered  <= filter_enable && flag_c;
      score     <= score_enable ? 17'(dot_q + 17'sd32768) : 17'd0;
      dot_value <= dot_q;
    end
  end

endmodule
`default_nettype wire

### rtl/core/fdpf_checker.sv
// ----------------------------------------------------------------------------
// fdpf_checker: port-level assertions for the facing dot product filter.
// Checks output ranges, handshake holding and stall coupling.
// ----------------------------------------------------------------------------
`default_nettype none
module fdpf_checker (
  input wire               clk,
  input wire               rst,
  input wire               in_stall,
  input wire               out_valid,
  input wire               out_stall,
  input wire [16:0]        score,
  input wire signed [16:0] dot_value
);

  a_dot_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (dot_value <= 17'sd32768 && dot_value >= -17'sd32768))
    else $error("dot_value out of range");

  a_score_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (score <= 17'd65536))
    else $error("score out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(dot_value)))
    else $error("stalled output changed");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output backpressure");

endmodule

bind facing_dot_product_filter_unit fdpf_checker u_fdpf_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .score(score), .dot_value(dot_value)
);
`default_nettype wire

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench of the facing dot product filter unit.
// Drives random and directed object transactions, predicts each result with a
// CORDIC model of its own, and compares every output transaction in order.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;

  // Result of one object transaction as the unit reports it.
  typedef struct {
    logic        flag;
    logic [16:0] score;
    logic [16:0] dot;
  } facing_result_t;

  // The scoreboard keeps its own copy of the registers, predicts the result
  // of every accepted object and compares the unit's outputs in order.
  class facing_scoreboard;
    longint tgt_x, tgt_y, thr;
    bit [2:0] rule;
    bit flt_en, scr_en;
    facing_result_t pending[$];
    int mismatches;

    function void reset_regs();
      tgt_x = 65536; tgt_y = 0; thr = 0; rule = fdpf_pkg::RULE_LE; flt_en = 0; scr_en = 0;
    endfunction

    function void write_reg(fdpf_pkg::reg_index_t idx, logic [31:0] val);
      case (idx)
        fdpf_pkg::REG_TARGET_X:  tgt_x = longint'($signed(val));
        fdpf_pkg::REG_TARGET_Y:  tgt_y = longint'($signed(val));
        fdpf_pkg::REG_THRESHOLD: thr = longint'($signed(val[16:0]));
        fdpf_pkg::REG_RULE:      rule = val[2:0];
        fdpf_pkg::REG_FILTER_EN: flt_en = val[0];
        fdpf_pkg::REG_SCORE_EN:  scr_en = val[0];
        default: ;
      endcase
    endfunction

    function longint atan_of(int i);
      longint t[20] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                        21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                        333772, 166886, 83443, 41722, 20861, 10430, 5215, 2608,
                        1304};
      return t[i];
    endfunction

    // Angle of a nonzero vector as a 32-bit binary angle.
    function bit [31:0] vector_angle(longint x, longint y);
      bit [31:0] z;
      longint xs, ys;
      z = 0;
      if (x < 0) begin
        x = -x; y = -y; z = 32'h8000_0000;
      end
      for (int i = 0; i < 20; i++) begin
        xs = x >>> i; ys = y >>> i;
        if (y > 0) begin
          x = x + ys; y = y - xs; z = z + 32'(atan_of(i));
        end else begin
          x = x - ys; y = y + xs; z = z - 32'(atan_of(i));
        end
      end
      return z;
    endfunction

    // Cosine of a binary angle in Q1.15, saturated to plus or minus one.
    function longint cosine_q15(bit [31:0] a);
      bit flip;
      longint x, y, z, xs, ys, r;
      bit [31:0] s;
      flip = 0; x = 652032874; y = 0;
      s = a + 32'h4000_0000;
      if (s[31]) begin
        flip = 1; a = a + 32'h8000_0000;
      end
      z = longint'($signed(a));
      for (int i = 0; i < 20; i++) begin
        xs = x >>> i; ys = y >>> i;
        if (z >= 0) begin
          x = x - ys; y = y + xs; z = z - atan_of(i);
        end else begin
          x = x + ys; y = y - xs; z = z + atan_of(i);
        end
      end
      r = (x + 16384) >>> 15;
      if (flip) r = -r;
      if (r > 32768) r = 32768;
      if (r < -32768) r = -32768;
      return r;
    endfunction

    function void note_object(logic [31:0] px, logic [31:0] py, logic [15:0] hd);
      longint dx, dy, dot, lim;
      bit [31:0] phi;
      facing_result_t e;
      dx = tgt_x - longint'($signed(px));
      dy = tgt_y - longint'($signed(py));
      dot = 0; lim = 64'sd1 << 31;
      if (dx != 0 || dy != 0) begin
        while (dx < lim && dx > -lim && dy < lim && dy > -lim) begin
          dx = dx * 2; dy = dy * 2;
        end
        phi = vector_angle(dx, dy);
        dot = cosine_q15(phi - {hd, 16'h0});
      end
      e.flag = 0;
      if (flt_en) begin
        case (rule)
          fdpf_pkg::RULE_LT: e.flag = dot < thr;
          fdpf_pkg::RULE_LE: e.flag = dot <= thr;
          fdpf_pkg::RULE_EQ: e.flag = dot == thr;
          fdpf_pkg::RULE_GE: e.flag = dot >= thr;
          default: e.flag = dot > thr;
        endcase
      end
      e.score = scr_en ? 17'(dot + 32768) : 17'd0;
      e.dot = 17'(dot);
      pending.push_back(e);
    endfunction

    function void check_result(logic f, logic [16:0] sc, logic [16:0] dv);
      facing_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output transaction: flag %0b score %0d dot %0d",
                   f, sc, $signed(dv));
        return;
      end
      e = pending.pop_front();
      if (f !== e.flag || sc !== e.score || dv !== e.dot) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: flag %0b/%0b score %0d/%0d dot %0d/%0d (exp/act)",
                   e.flag, f, e.score, sc, $signed(e.dot), $signed(dv));
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [2:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;
  logic in_valid = 0, in_stall;
  logic signed [31:0] position_x = 0, position_y = 0;
  logic [15:0] heading = 0;
  logic out_valid, out_stall = 0, filtered;
  logic [16:0] score;
  logic signed [16:0] dot_value;

  facing_scoreboard board = new();
  longint cycles = 0;
  // Long receiver hold-off request, served by the receiver process.
  int hold_request = 0;
  bit stall_random = 1;

  facing_dot_product_filter_unit i_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Scoreboard updates on acceptance, sampled at the edge itself.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) board.note_object(position_x, position_y, heading);
    if (!rst && out_valid && !out_stall) board.check_result(filtered, score, dot_value);
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("[facing_dot_product_filter_unit] ERROR");
      $finish;
    end
  end

  // Receiver: random stalls per result, plus a long hold-off on request.
  initial begin
    int w;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        out_stall <= 1;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end
      w = stall_random ? $urandom_range(0, 13) : 0;
      if ($urandom_range(0, 3) == 0) w = 0;
      if (w > 0) begin
        out_stall <= 1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic write_reg(fdpf_pkg::reg_index_t idx, logic [31:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    board.write_reg(idx, val);
    cfg_we <= 0;
  endtask

  task automatic send_object(logic [31:0] px, logic [31:0] py, logic [15:0] hd,
                             int gap);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1; position_x <= px; position_y <= py; heading <= hd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Waits for all expected results, then lets the chain drain fully.
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      2: return 32'($signed($urandom_range(0, 64)) - 32);
      3: return board.tgt_x[31:0] + 32'($urandom_range(0, 6)) - 3;
      default: return {$urandom_range(0, 1) ? 16'hffff : 16'h0, 16'($urandom())};
    endcase
  endfunction

  task automatic random_phase(int n, bit gaps);
    logic [31:0] px, py;
    for (int k = 0; k < n; k++) begin
      px = rand_coord(); py = rand_coord();
      // Some objects sit exactly on the target.
      if ($urandom_range(0, 15) == 0) begin
        px = board.tgt_x[31:0]; py = board.tgt_y[31:0];
      end
      send_object(px, py, 16'($urandom()),
                  (gaps && $urandom_range(0, 2) != 0) ? $urandom_range(0, 13) : 0);
    end
  endtask

  initial begin
    logic [31:0] thr_vals[5] = '{32'h1_8000, 32'h0_8000, 32'h0, 32'h0_4000, 32'h1_FFFF};
    repeat (4) @(posedge clk);
    rst <= 0;
    board.reset_regs();
    @(posedge clk);

    // Directed: reset settings, then extremes of positions and headings.
    send_object(32'h0, 32'h0, 16'h0, 0);
    send_object(32'h0001_0000, 32'h0, 16'h0, 0);
    send_object(32'h7fff_ffff, 32'h7fff_ffff, 16'hffff, 0);
    send_object(32'h8000_0000, 32'h8000_0000, 16'h8000, 0);
    send_object(32'h8000_0000, 32'h7fff_ffff, 16'h4000, 0);
    send_object(32'h0, 32'h0, 16'h8000, 0);
    drain();
    write_reg(fdpf_pkg::REG_FILTER_EN, 32'h1);
    write_reg(fdpf_pkg::REG_SCORE_EN, 32'h1);
    write_reg(fdpf_pkg::REG_TARGET_X, 32'h7fff_ffff);
    write_reg(fdpf_pkg::REG_TARGET_Y, 32'h8000_0000);
    for (int r = 0; r < 8; r++) begin
      write_reg(fdpf_pkg::REG_RULE, r);
      write_reg(fdpf_pkg::REG_THRESHOLD, (r % 2) ? 32'h0_8000 : 32'h1_8000);
      send_object(32'h8000_0000, 32'h7fff_ffff, 16'h0, 0);
      send_object(32'h7fff_ffff, 32'h8000_0000, 16'h0, 0);
      drain();
    end
    write_reg(fdpf_pkg::REG_TARGET_X, 32'h0);
    write_reg(fdpf_pkg::REG_TARGET_Y, 32'h0);
    write_reg(fdpf_pkg::REG_THRESHOLD, 32'h0);
    send_object(32'h0, 32'h0, 16'h0, 0);
    send_object(32'hffff_ffff, 32'h0, 16'h8000, 0);
    drain();

    // Random phases over changing settings.
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(fdpf_pkg::REG_TARGET_X, (ph == 3) ? 32'h8000_0000 : $urandom());
      write_reg(fdpf_pkg::REG_TARGET_Y,
                (ph == 4) ? 32'h7fff_ffff : 32'($urandom_range(0, 1 << 20)));
      write_reg(fdpf_pkg::REG_THRESHOLD, thr_vals[ph % 5] | ($urandom() & 32'hfffe_0000));
      write_reg(fdpf_pkg::REG_RULE, ph % 8);
      write_reg(fdpf_pkg::REG_FILTER_EN, (ph % 3 != 2) | ($urandom() & 32'hffff_fffe));
      write_reg(fdpf_pkg::REG_SCORE_EN, ph % 2 == 0);
      if (ph == 5) begin
        // Hold off the receiver long while the sender keeps offering.
        hold_request = 150;
        random_phase(90, 0);
      end else if (ph == 7) begin
        stall_random = 0;
        random_phase(48, 0);
        stall_random = 1;
      end else begin
        random_phase(48, 1);
      end
      // The sender pauses here until every expected result has come.
      drain();
    end

    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("[facing_dot_product_filter_unit] OK");
    end else begin
      $display("[facing_dot_product_filter_unit] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
